// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the encoder interval speed block, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check on the rising clock edge, switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("encoder interval speed: assertion failed");

// Concurrent check on the rising clock edge that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("encoder interval speed: assertion failed");

`else

`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== design/eis_pkg.sv =====
// Types, constants and codes shared by the encoder interval speed block.
package eis_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int MAX_RESULTS      = 4;

  localparam int OP_W     = 2;
  localparam int CHAN_W   = 2;
  localparam int TICKS_W  = 16;
  localparam int THR_W    = 16;
  localparam int SCALE_W  = 32;
  localparam int DELTA_W  = 16;
  localparam int RPM_W    = 32;
  localparam int PROD_W   = DELTA_W + SCALE_W;
  localparam int FRAC_W   = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_EDGE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_ARM   = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_INTERVAL_TICKS = 1'b0,
    REG_RPM_SCALE      = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HIT,
    ST_SAMPLE,
    ST_MULT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic do_edge;
    logic do_clear;
    logic do_arm;
    logic do_tick;
    logic walk_start;
    logic do_sample;
    logic do_mult;
    logic load_hit;
    logic load_sample;
    logic walk_next;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ch_ok;
    logic thr_one;
    logic irem_one;
    logic out_free;
    logic walk_last;
    logic walk_emit;
  } status_t;

endpackage

// ===== design/encoder_interval_speed.sv =====
// Top level of the multi-channel quadrature encoder counter with interval speed sampling.
//
// The block keeps a wrapping position per encoder channel, an armable edge
// countdown per channel, and an interval prescaler driven by timer ticks.
// Items arrive on the slave stream: tuser carries the operation (edge, tick,
// clear, arm) and tdata the channel, the phase B level and the countdown
// load. An item that gives no result occupies the block for the transfer and
// a decode step. An edge that ends a countdown gives one result, which waits
// for the output register to be free. A tick that expires the interval walks
// every channel through the shared sample stage and the single 16 by 32 bit
// multiplier: each of the first four channels goes through sample, multiply
// and emit and gives a result, each further channel is only sampled, and
// the walk holds while the master side stalls a result. Results sit in an
// output register, so the block takes the next transfer while a result
// still waits. Speed is the signed delta times the Q16.16 scale register,
// truncated toward zero and clamped to 32 bits; delta is clamped to 16 bits.
// Registers sit on the APB port at byte 0 (interval ticks, which also
// reloads the prescaler) and byte 4 (rpm scale); write them only while the
// block is idle.
`include "assert_macros.svh"

module encoder_interval_speed #(
  parameter int NUM_CHANNELS = eis_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = eis_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata: channel[1:0], phase_b[2], threshold_count[18:3], zero fill above.
  input  logic [eis_pkg::IN_TDATA_W-1:0]  s_tdata,
  // tuser: op[1:0].
  input  logic [eis_pkg::IN_TUSER_W-1:0]  s_tuser,
  // Result stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata: out_channel[1:0], delta_count[17:2], speed_rpm[49:18], zero fill above.
  output logic [eis_pkg::OUT_TDATA_W-1:0] m_tdata,
  // tuser: threshold_hit[0], interval_done[1].
  output logic [eis_pkg::OUT_TUSER_W-1:0] m_tuser,
  output logic                            m_tlast,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [eis_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [eis_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [eis_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import eis_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Every access completes in its access cycle.
  assign pready = 1'b1;

  eis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  eis_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .cmd      (cmd),
    .status   (status)
  );

  // The block works on one item at a time: after a transfer it is busy.
  `ASSERT_RST(a_busy_after_transfer, clk, rst, (s_tvalid && s_tready) |=> !s_tready)

  // The result register is loaded only when it is empty or being drained.
  `ASSERT_RST(a_load_when_free, clk, rst, (cmd.load_hit || cmd.load_sample) |=> m_tvalid)
  `ASSERT_RST(a_no_overwrite, clk, rst, (cmd.load_hit || cmd.load_sample) |-> (!m_tvalid || m_tready))

  // A countdown hit is a lone result with no interval data.
  `ASSERT_RST(a_hit_alone, clk, rst, (m_tvalid && m_tuser[0]) |-> (m_tlast && !m_tuser[1] && m_tdata[49:2] == 48'd0))

endmodule

// ===== design/eis_ctrl.sv =====
// Sequencer of the encoder interval speed block: decodes items and walks the channels.
module eis_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  eis_pkg::status_t status,
  output eis_pkg::cmd_t    cmd
);
  import eis_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        if (status.op == OP_TICK && status.irem_one) begin
          state_next = ST_SAMPLE;
        end else if (status.op == OP_EDGE && status.ch_ok && status.thr_one) begin
          state_next = ST_HIT;
        end
      end
      ST_HIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SAMPLE: begin
        if (status.walk_emit) begin
          state_next = ST_MULT;
        end else if (status.walk_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_MULT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.walk_last ? ST_IDLE : ST_SAMPLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready     = 1'b1;
        cmd.latch_in = s_tvalid;
      end
      ST_DECODE: begin
        case (status.op)
          OP_EDGE: begin
            cmd.do_edge = status.ch_ok;
          end
          OP_TICK: begin
            cmd.do_tick    = 1'b1;
            cmd.walk_start = status.irem_one;
          end
          OP_CLEAR: begin
            cmd.do_clear = status.ch_ok;
          end
          OP_ARM: begin
            cmd.do_arm = status.ch_ok;
          end
          default: begin
            cmd = '0;
          end
        endcase
      end
      ST_HIT: begin
        cmd.load_hit = status.out_free;
      end
      ST_SAMPLE: begin
        cmd.do_sample = 1'b1;
        cmd.walk_next = !status.walk_emit && !status.walk_last;
      end
      ST_MULT: begin
        cmd.do_mult = 1'b1;
      end
      ST_EMIT: begin
        cmd.load_sample = status.out_free;
        cmd.walk_next   = status.out_free && !status.walk_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/eis_dp.sv =====
// Datapath of the encoder interval speed block: channel state, speed math and result register.
module eis_dp #(
  parameter int NUM_CHANNELS = eis_pkg::NUM_CHANNELS_DEF,
  parameter int COUNT_BITS   = eis_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [eis_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic [eis_pkg::IN_TUSER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [eis_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic [eis_pkg::OUT_TUSER_W-1:0]    m_tuser,
  output logic                               m_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [eis_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [eis_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [eis_pkg::APB_DATA_W-1:0]     prdata,
  input  eis_pkg::cmd_t                      cmd,
  output eis_pkg::status_t                   status
);
  import eis_pkg::*;

  localparam int CW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DW       = (COUNT_BITS > DELTA_W) ? COUNT_BITS : DELTA_W;
  localparam int LAST_OUT = ((NUM_CHANNELS < MAX_RESULTS) ? NUM_CHANNELS : MAX_RESULTS) - 1;
  localparam logic signed [DW-1:0] DMAX = DW'(2 ** (DELTA_W - 1) - 1);
  localparam logic signed [DW-1:0] DMIN = DW'(-(2 ** (DELTA_W - 1)));
  localparam logic [RPM_W-1:0] RPM_POS_MAX = {1'b0, {(RPM_W-1){1'b1}}};
  localparam logic [RPM_W-1:0] RPM_NEG_MAX = {1'b1, {(RPM_W-1){1'b0}}};

  // Channel state.
  logic [COUNT_BITS-1:0] position          [NUM_CHANNELS];
  logic [COUNT_BITS-1:0] previous_position [NUM_CHANNELS];
  logic [THR_W-1:0]      threshold_remaining [NUM_CHANNELS];
  logic [TICKS_W-1:0]    interval_remaining;
  logic [TICKS_W-1:0]    interval_ticks;
  logic [SCALE_W-1:0]    rpm_scale;

  // Latched item and walk pointer.
  op_t                   op_lat;
  logic [CHAN_W-1:0]     ch_lat;
  logic                  phase_b_lat;
  logic [THR_W-1:0]      thr_count_lat;
  logic [CW-1:0]         idx;

  // Speed pipeline.
  logic signed [DELTA_W-1:0] delta_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      neg_r;

  // Result register.
  logic [CHAN_W-1:0]         out_channel;
  logic [DELTA_W-1:0]        out_delta;
  logic [RPM_W-1:0]          out_rpm;
  logic                      out_hit;
  logic                      out_done;
  logic                      out_last;

  logic                      cfg_wr;
  logic [COUNT_BITS-1:0]     diff;
  logic signed [DW-1:0]      diff_ext;
  logic [DELTA_W-1:0]        delta_sat;
  logic [DELTA_W-1:0]        mag;
  logic [RPM_W-1:0]          prod_hi;
  logic [RPM_W-1:0]          rpm_sat;

  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_INTERVAL_TICKS: prdata = APB_DATA_W'(interval_ticks);
      REG_RPM_SCALE:      prdata = APB_DATA_W'(rpm_scale);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks     <= '0;
      rpm_scale          <= '0;
      interval_remaining <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[2]))
          REG_INTERVAL_TICKS: begin
            interval_ticks     <= pwdata[TICKS_W-1:0];
            interval_remaining <= pwdata[TICKS_W-1:0];
          end
          REG_RPM_SCALE: begin
            rpm_scale <= pwdata[SCALE_W-1:0];
          end
          default: begin
            rpm_scale <= rpm_scale;
          end
        endcase
      end
      if (cmd.do_tick && interval_remaining != '0) begin
        interval_remaining <= (interval_remaining == TICKS_W'(1)) ?
                              interval_ticks : interval_remaining - TICKS_W'(1);
      end
    end
  end

  // Item latch; the walk pointer doubles as the addressed channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.latch_in) begin
      idx <= CW'(s_tdata[CHAN_W-1:0]);
    end else if (cmd.walk_start) begin
      idx <= '0;
    end else if (cmd.walk_next) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_lat        <= op_t'(s_tuser[OP_W-1:0]);
      ch_lat        <= s_tdata[CHAN_W-1:0];
      phase_b_lat   <= s_tdata[CHAN_W];
      thr_count_lat <= s_tdata[CHAN_W+THR_W:CHAN_W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        position[i]            <= '0;
        previous_position[i]   <= '0;
        threshold_remaining[i] <= '0;
      end
    end else begin
      if (cmd.do_edge) begin
        position[idx] <= phase_b_lat ? position[idx] + COUNT_BITS'(1) :
                                       position[idx] - COUNT_BITS'(1);
        if (threshold_remaining[idx] != '0) begin
          threshold_remaining[idx] <= threshold_remaining[idx] - THR_W'(1);
        end
      end
      if (cmd.do_clear) begin
        position[idx] <= '0;
      end
      if (cmd.do_arm) begin
        threshold_remaining[idx] <= thr_count_lat;
      end
      if (cmd.do_sample) begin
        previous_position[idx] <= position[idx];
      end
    end
  end

  // Wrapped difference, read as signed and clamped to the delta width.
  always_comb begin
    diff     = position[idx] - previous_position[idx];
    diff_ext = DW'($signed(diff));
    if (diff_ext > DMAX) begin
      delta_sat = DMAX[DELTA_W-1:0];
    end else if (diff_ext < DMIN) begin
      delta_sat = DMIN[DELTA_W-1:0];
    end else begin
      delta_sat = diff_ext[DELTA_W-1:0];
    end
  end

  assign mag = delta_r[DELTA_W-1] ? DELTA_W'(-delta_r) : DELTA_W'(delta_r);

  always_ff @(posedge clk) begin
    if (cmd.do_sample) begin
      delta_r <= $signed(delta_sat);
    end
    if (cmd.do_mult) begin
      prod_r <= PROD_W'(mag) * PROD_W'(rpm_scale);
      neg_r  <= delta_r[DELTA_W-1];
    end
  end

  assign prod_hi = prod_r[FRAC_W+RPM_W-1:FRAC_W];

  always_comb begin
    if (neg_r) begin
      rpm_sat = (prod_hi > RPM_NEG_MAX) ? RPM_NEG_MAX : RPM_W'(-prod_hi);
    end else begin
      rpm_sat = prod_hi[RPM_W-1] ? RPM_POS_MAX : prod_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_hit || cmd.load_sample) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hit) begin
      out_channel <= ch_lat;
      out_delta   <= '0;
      out_rpm     <= '0;
      out_hit     <= 1'b1;
      out_done    <= 1'b0;
      out_last    <= 1'b1;
    end else if (cmd.load_sample) begin
      out_channel <= CHAN_W'(idx);
      out_delta   <= delta_r;
      out_rpm     <= rpm_sat;
      out_hit     <= 1'b0;
      out_done    <= 1'b1;
      out_last    <= (idx == CW'(LAST_OUT));
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-CHAN_W-DELTA_W-RPM_W){1'b0}}, out_rpm, out_delta, out_channel};
  assign m_tuser = {out_done, out_hit};
  assign m_tlast = out_last;

  always_comb begin
    status.op        = op_lat;
    status.ch_ok     = (32'(ch_lat) < NUM_CHANNELS);
    status.thr_one   = (threshold_remaining[idx] == THR_W'(1));
    status.irem_one  = (interval_remaining == TICKS_W'(1));
    status.out_free  = !m_tvalid || m_tready;
    status.walk_last = (idx == CW'(NUM_CHANNELS - 1));
    status.walk_emit = (32'(idx) < MAX_RESULTS);
  end

endmodule
